[src/point_to_cylinder_distance_unit_defines.svh]
// ---------------------------------------------------------------------------
// Point-to-cylinder distance unit: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef POINT_TO_CYLINDER_DISTANCE_UNIT_DEFINES_SVH
`define POINT_TO_CYLINDER_DISTANCE_UNIT_DEFINES_SVH

// Same-cycle implication
`define PTCD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PTCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/ptcd_pkg.sv]
// ---------------------------------------------------------------------------
// Point-to-cylinder distance package
// Configuration register indexes shared by the interfaces and the top level.
// ---------------------------------------------------------------------------
package ptcd_pkg;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_X = 3'd0,
        CFG_START_Y = 3'd1,
        CFG_START_Z = 3'd2,
        CFG_AXIS_X  = 3'd3,
        CFG_AXIS_Y  = 3'd4,
        CFG_AXIS_Z  = 3'd5,
        CFG_RADIUS  = 3'd6
    } cfg_idx_t;

endpackage

[src/ptcd_ifs.sv]
// ---------------------------------------------------------------------------
// Point-to-cylinder distance channels
// Valid/ready interfaces for query points, results and register writes.
// ---------------------------------------------------------------------------
interface ptcd_point_if #(parameter int COORD_WIDTH = 32) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    output ready);
endinterface

interface ptcd_dist_if #(parameter int COORD_WIDTH = 32) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] signed_distance;
    logic                          axis_degenerate;

    modport source (output valid, output signed_distance, output axis_degenerate,
                    input ready);
    modport sink   (input valid, input signed_distance, input axis_degenerate,
                    output ready);
endinterface

interface ptcd_cfg_if import ptcd_pkg::*; #(parameter int COORD_WIDTH = 32) ();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [COORD_WIDTH-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/ptcd_sqrt_pipe.sv]
// ---------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one root bit per register stage, with a sideband word
// that travels alongside each item.
// ---------------------------------------------------------------------------
module ptcd_sqrt_pipe #(
    parameter int IN_W = 64,
    parameter int SB_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [IN_W-1:0]   x_in,
    input  logic [SB_W-1:0]   sb_in,
    output logic              out_valid,
    output logic [IN_W/2-1:0] root_out,
    output logic [SB_W-1:0]   sb_out
);

    localparam int OUT_W = IN_W / 2;
    localparam int R_W   = OUT_W + 2;

    logic [IN_W-1:0]  x_reg    [OUT_W];
    logic [R_W-1:0]   rem_reg  [OUT_W];
    logic [OUT_W-1:0] root_reg [OUT_W];
    logic [SB_W-1:0]  sb_reg   [OUT_W];
    logic             v_reg    [OUT_W];

    genvar g;
    generate
        for (g = 0; g < OUT_W; g++)
        begin : g_stage
            logic [IN_W-1:0]  x_cur;
            logic [R_W-1:0]   rem_cur;
            logic [OUT_W-1:0] root_cur;
            logic [SB_W-1:0]  sb_cur;
            logic             v_cur;
            logic [R_W-1:0]   rem_sh;
            logic [R_W-1:0]   trial;
            logic             take;
            logic [R_W-1:0]   rem_next;
            logic [OUT_W-1:0] root_next;

            if (g == 0)
            begin : g_first
                assign x_cur    = x_in;
                assign rem_cur  = '0;
                assign root_cur = '0;
                assign sb_cur   = sb_in;
                assign v_cur    = in_valid;
            end
            else
            begin : g_rest
                assign x_cur    = x_reg[g-1];
                assign rem_cur  = rem_reg[g-1];
                assign root_cur = root_reg[g-1];
                assign sb_cur   = sb_reg[g-1];
                assign v_cur    = v_reg[g-1];
            end

            // bring down two radicand bits, try root*4+1
            always_comb
            begin
                rem_sh    = {rem_cur[R_W-3:0], x_cur[IN_W-1 -: 2]};
                trial     = {root_cur, 2'b01};
                take      = (rem_sh >= trial);
                rem_next  = take ? (rem_sh - trial) : rem_sh;
                root_next = {root_cur[OUT_W-2:0], take};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[g] <= 1'b0;
                else if (en)
                    v_reg[g] <= v_cur;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[g]    <= {x_cur[IN_W-3:0], 2'b00};
                    rem_reg[g]  <= rem_next;
                    root_reg[g] <= root_next;
                    sb_reg[g]   <= sb_cur;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[OUT_W-1];
    assign root_out  = root_reg[OUT_W-1];
    assign sb_out    = sb_reg[OUT_W-1];

endmodule

[src/ptcd_div_pipe.sv]
// ---------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per register stage, sideband carried.
// ---------------------------------------------------------------------------
module ptcd_div_pipe #(
    parameter int N_W  = 66,
    parameter int D_W  = 32,
    parameter int SB_W = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [N_W-1:0]  num_in,
    input  logic [D_W-1:0]  den_in,
    input  logic [SB_W-1:0] sb_in,
    output logic            out_valid,
    output logic [N_W-1:0]  quot_out,
    output logic [SB_W-1:0] sb_out
);

    logic [N_W-1:0]  n_reg   [N_W];
    logic [D_W-1:0]  d_reg   [N_W];
    logic [D_W-1:0]  rem_reg [N_W];
    logic [N_W-1:0]  q_reg   [N_W];
    logic [SB_W-1:0] sb_reg  [N_W];
    logic            v_reg   [N_W];

    genvar g;
    generate
        for (g = 0; g < N_W; g++)
        begin : g_stage
            logic [N_W-1:0]  n_cur;
            logic [D_W-1:0]  d_cur;
            logic [D_W-1:0]  rem_cur;
            logic [N_W-1:0]  q_cur;
            logic [SB_W-1:0] sb_cur;
            logic            v_cur;
            logic [D_W:0]    rem_sh;
            logic            take;
            logic [D_W:0]    rem_next;

            if (g == 0)
            begin : g_first
                assign n_cur   = num_in;
                assign d_cur   = den_in;
                assign rem_cur = '0;
                assign q_cur   = '0;
                assign sb_cur  = sb_in;
                assign v_cur   = in_valid;
            end
            else
            begin : g_rest
                assign n_cur   = n_reg[g-1];
                assign d_cur   = d_reg[g-1];
                assign rem_cur = rem_reg[g-1];
                assign q_cur   = q_reg[g-1];
                assign sb_cur  = sb_reg[g-1];
                assign v_cur   = v_reg[g-1];
            end

            // shift in next dividend bit, subtract divisor if it fits
            always_comb
            begin
                rem_sh   = {rem_cur, n_cur[N_W-1]};
                take     = (rem_sh >= {1'b0, d_cur});
                rem_next = take ? (rem_sh - {1'b0, d_cur}) : rem_sh;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[g] <= 1'b0;
                else if (en)
                    v_reg[g] <= v_cur;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    n_reg[g]   <= {n_cur[N_W-2:0], 1'b0};
                    d_reg[g]   <= d_cur;
                    rem_reg[g] <= rem_next[D_W-1:0];
                    q_reg[g]   <= {q_cur[N_W-2:0], take};
                    sb_reg[g]  <= sb_cur;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[N_W-1];
    assign quot_out  = q_reg[N_W-1];
    assign sb_out    = sb_reg[N_W-1];

endmodule

[src/point_to_cylinder_distance_unit.sv]
// ---------------------------------------------------------------------------
// Point-to-cylinder distance unit
// Signed distance of a streamed point to a configured finite cylinder.
// ---------------------------------------------------------------------------
// Takes one point per clock while the output is not stalled and returns
// one signed distance per point, in order, after the three bit-per-stage
// square roots and the bit-per-stage divider for the axis projection have
// worked on it. A stalled output freezes the whole pipeline; in_ch.ready
// follows it in the same cycle. Registers are written at any time through
// cfg_ch (always ready) but must only change while no point is in flight.
// A zero axis returns distance 0 with axis_degenerate set.
`include "point_to_cylinder_distance_unit_defines.svh"

module point_to_cylinder_distance_unit import ptcd_pkg::*; #(
    parameter int COORD_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    ptcd_cfg_if.sink    cfg_ch,
    ptcd_point_if.sink  in_ch,
    ptcd_dist_if.source out_ch
);

    localparam int W = COORD_WIDTH;

    // configuration registers
    logic signed [W-1:0] start_reg [3];
    logic signed [W-1:0] axis_reg  [3];
    logic [W-2:0]        radius_reg;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                start_reg[k] <= '0;
                axis_reg[k]  <= '0;
            end
            radius_reg <= '0;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_idx_t'(cfg_ch.index))
                CFG_START_X: start_reg[0] <= cfg_ch.data;
                CFG_START_Y: start_reg[1] <= cfg_ch.data;
                CFG_START_Z: start_reg[2] <= cfg_ch.data;
                CFG_AXIS_X:  axis_reg[0]  <= cfg_ch.data;
                CFG_AXIS_Y:  axis_reg[1]  <= cfg_ch.data;
                CFG_AXIS_Z:  axis_reg[2]  <= cfg_ch.data;
                CFG_RADIUS:  radius_reg   <= cfg_ch.data[W-2:0];
                default: ;
            endcase
        end
    end

    // global pipeline enable: advance unless the output item is held
    logic out_valid_reg;
    logic en;

    assign en          = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = en;

    // stage 1: point minus start
    logic signed [W-1:0] pt [3];
    logic signed [W:0]   d1_next  [3];
    logic signed [W:0]   d1_reg   [3];
    logic signed [W-1:0] a1_reg   [3];
    logic                s1_v_reg;

    assign pt[0] = in_ch.point_x;
    assign pt[1] = in_ch.point_y;
    assign pt[2] = in_ch.point_z;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            d1_next[k] = $signed({pt[k][W-1], pt[k]})
                       - $signed({start_reg[k][W-1], start_reg[k]});
    end

    // stage 2: per-axis products
    logic signed [2*W:0]   da2_next [3];
    logic signed [2*W+1:0] dsq_full [3];
    logic signed [2*W-1:0] asq_full [3];
    logic signed [2*W:0]   da2_reg  [3];
    logic [2*W-1:0]        dd2_reg  [3];
    logic [2*W-1:0]        aa2_reg  [3];
    logic                  s2_v_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            da2_next[k] = d1_reg[k] * a1_reg[k];
            dsq_full[k] = d1_reg[k] * d1_reg[k];
            asq_full[k] = a1_reg[k] * a1_reg[k];
        end
    end

    // stage 3: sums
    logic signed [2*W+2:0] dot3_next;
    logic [2*W+1:0]        dd3_next;
    logic [2*W-1:0]        aa3_next;
    logic signed [2*W+2:0] dot3_reg;
    logic [2*W+1:0]        dd3_reg;
    logic [2*W-1:0]        aa3_reg;
    logic                  s3_v_reg;

    always_comb
    begin
        dot3_next = (2*W+3)'(da2_reg[0]) + (2*W+3)'(da2_reg[1]) + (2*W+3)'(da2_reg[2]);
        dd3_next  = {2'b00, dd2_reg[0]} + {2'b00, dd2_reg[1]} + {2'b00, dd2_reg[2]};
        aa3_next  = aa2_reg[0] + aa2_reg[1] + aa2_reg[2];
    end

    // stage 4: dot magnitude and sign, zero axis test
    logic signed [2*W+2:0] dot_abs;
    logic [2*W+1:0]        dm4_reg;
    logic [2*W+1:0]        dd4_reg;
    logic [2*W-1:0]        aa4_reg;
    logic                  le0_4_reg;
    logic                  deg4_reg;
    logic                  s4_v_reg;

    assign dot_abs = dot3_reg[2*W+2] ? -dot3_reg : dot3_reg;

    // stage 5: projection beyond end point test
    logic [2*W+1:0] dm5_reg;
    logic [2*W+1:0] dd5_reg;
    logic [2*W-1:0] aa5_reg;
    logic           le0_5_reg;
    logic           ge5_reg;
    logic           deg5_reg;
    logic           s5_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= in_ch.valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            s5_v_reg <= s4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                d1_reg[k]  <= d1_next[k];
                a1_reg[k]  <= axis_reg[k];
                da2_reg[k] <= da2_next[k];
                dd2_reg[k] <= dsq_full[k][2*W-1:0];
                aa2_reg[k] <= asq_full[k];
            end
            dot3_reg  <= dot3_next;
            dd3_reg   <= dd3_next;
            aa3_reg   <= aa3_next;
            dm4_reg   <= dot_abs[2*W+1:0];
            dd4_reg   <= dd3_reg;
            aa4_reg   <= aa3_reg;
            le0_4_reg <= dot3_reg[2*W+2] || (dot3_reg == '0);
            deg4_reg  <= (aa3_reg == '0);
            dm5_reg   <= dm4_reg;
            dd5_reg   <= dd4_reg;
            aa5_reg   <= aa4_reg;
            le0_5_reg <= le0_4_reg;
            ge5_reg   <= (dm4_reg >= {2'b00, aa4_reg});
            deg5_reg  <= deg4_reg;
        end
    end

    // axis length
    localparam int SB1_W = 4*W + 7;
    logic             q1_v;
    logic [W-1:0]     q1_len;
    logic [SB1_W-1:0] q1_sb;
    logic [2*W+1:0]   q1_dm;
    logic [2*W+1:0]   q1_dd;
    logic             q1_le0;
    logic             q1_ge;
    logic             q1_deg;

    ptcd_sqrt_pipe #(
        .IN_W (2*W),
        .SB_W (SB1_W)
    ) u_len_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s5_v_reg),
        .x_in      (aa5_reg),
        .sb_in     ({dm5_reg, dd5_reg, le0_5_reg, ge5_reg, deg5_reg}),
        .out_valid (q1_v),
        .root_out  (q1_len),
        .sb_out    (q1_sb)
    );

    assign {q1_dm, q1_dd, q1_le0, q1_ge, q1_deg} = q1_sb;

    // projection length along the axis
    localparam int SB2_W = 3*W + 5;
    logic             q2_v;
    logic [2*W+1:0]   q2_quot;
    logic [SB2_W-1:0] q2_sb;
    logic [W-1:0]     q2_len;
    logic [2*W+1:0]   q2_dd;
    logic             q2_le0;
    logic             q2_ge;
    logic             q2_deg;
    logic [W+1:0]     proj;

    ptcd_div_pipe #(
        .N_W  (2*W+2),
        .D_W  (W),
        .SB_W (SB2_W)
    ) u_proj_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (q1_v),
        .num_in    (q1_dm),
        .den_in    (q1_len),
        .sb_in     ({q1_len, q1_dd, q1_le0, q1_ge, q1_deg}),
        .out_valid (q2_v),
        .quot_out  (q2_quot),
        .sb_out    (q2_sb)
    );

    assign {q2_len, q2_dd, q2_le0, q2_ge, q2_deg} = q2_sb;
    assign proj = q2_quot[W+1:0];

    // stage 6: projection squared, along-axis excess
    logic [2*W+3:0] p2_next;
    logic [W+1:0]   ex6_next;
    logic [2*W+3:0] p2_6_reg;
    logic [W+1:0]   ex6_reg;
    logic [2*W+1:0] dd6_reg;
    logic           deg6_reg;
    logic           s6_v_reg;

    always_comb
    begin
        p2_next = proj * proj;
        if (q2_le0)
            ex6_next = proj;
        else if (q2_ge)
            ex6_next = proj - {2'b00, q2_len};
        else
            ex6_next = '0;
    end

    // stage 7: squared perpendicular distance, clamped at zero
    logic [2*W+3:0] pd7_reg;
    logic [W+1:0]   ex7_reg;
    logic           deg7_reg;
    logic           s7_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_v_reg <= 1'b0;
            s7_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s6_v_reg <= q2_v;
            s7_v_reg <= s6_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_6_reg <= p2_next;
            ex6_reg  <= ex6_next;
            dd6_reg  <= q2_dd;
            deg6_reg <= q2_deg;
            pd7_reg  <= ({2'b00, dd6_reg} >= p2_6_reg) ? ({2'b00, dd6_reg} - p2_6_reg) : '0;
            ex7_reg  <= ex6_reg;
            deg7_reg <= deg6_reg;
        end
    end

    // perpendicular distance
    logic           q3_v;
    logic [W+1:0]   q3_perp;
    logic [W+2:0]   q3_sb;
    logic [W+1:0]   q3_ex;
    logic           q3_deg;

    ptcd_sqrt_pipe #(
        .IN_W (2*W+4),
        .SB_W (W+3)
    ) u_perp_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s7_v_reg),
        .x_in      (pd7_reg),
        .sb_in     ({ex7_reg, deg7_reg}),
        .out_valid (q3_v),
        .root_out  (q3_perp),
        .sb_out    (q3_sb)
    );

    assign {q3_ex, q3_deg} = q3_sb;

    // stage 8: hull term and inside flag
    logic [W+1:0] rad_ext;
    logic         in8_reg;
    logic [W+1:0] hull8_reg;
    logic [W+1:0] ex8_reg;
    logic         deg8_reg;
    logic         s8_v_reg;

    assign rad_ext = {3'b000, radius_reg};

    // stage 9: squares
    logic [2*W+3:0] h2_9_reg;
    logic [2*W+3:0] e2_9_reg;
    logic           in9_reg;
    logic           deg9_reg;
    logic           s9_v_reg;

    // stage 10: sum of squares
    logic [2*W+5:0] sum10_reg;
    logic           in10_reg;
    logic           deg10_reg;
    logic           s10_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s8_v_reg  <= 1'b0;
            s9_v_reg  <= 1'b0;
            s10_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s8_v_reg  <= q3_v;
            s9_v_reg  <= s8_v_reg;
            s10_v_reg <= s9_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in8_reg   <= (q3_perp < rad_ext);
            hull8_reg <= (q3_perp < rad_ext) ? (rad_ext - q3_perp) : (q3_perp - rad_ext);
            ex8_reg   <= q3_ex;
            deg8_reg  <= q3_deg;
            h2_9_reg  <= hull8_reg * hull8_reg;
            e2_9_reg  <= ex8_reg * ex8_reg;
            in9_reg   <= in8_reg;
            deg9_reg  <= deg8_reg;
            sum10_reg <= {2'b00, h2_9_reg} + {2'b00, e2_9_reg};
            in10_reg  <= in9_reg;
            deg10_reg <= deg9_reg;
        end
    end

    // distance magnitude
    logic         q4_v;
    logic [W+2:0] q4_res;
    logic [1:0]   q4_sb;
    logic         q4_in;
    logic         q4_deg;

    ptcd_sqrt_pipe #(
        .IN_W (2*W+6),
        .SB_W (2)
    ) u_res_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s10_v_reg),
        .x_in      (sum10_reg),
        .sb_in     ({in10_reg, deg10_reg}),
        .out_valid (q4_v),
        .root_out  (q4_res),
        .sb_out    (q4_sb)
    );

    assign {q4_in, q4_deg} = q4_sb;

    // output stage: saturate, apply sign
    logic [W+2:0]        lim;
    logic [W-1:0]        mag;
    logic signed [W-1:0] dist_next;
    logic signed [W-1:0] dist_reg;
    logic                deg_reg;

    always_comb
    begin
        lim = ((W+3)'(1) << (W-1)) - (q4_in ? (W+3)'(0) : (W+3)'(1));
        mag = (q4_res > lim) ? lim[W-1:0] : q4_res[W-1:0];
        if (q4_deg)
            dist_next = '0;
        else if (q4_in)
            dist_next = -$signed(mag);
        else
            dist_next = $signed(mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= q4_v;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg <= dist_next;
            deg_reg  <= q4_deg;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.signed_distance = dist_reg;
    assign out_ch.axis_degenerate = deg_reg;

    // checks
    `PTCD_ASSERT_SAME(a_degen_zero, out_ch.valid && out_ch.axis_degenerate,
        out_ch.signed_distance == '0, "degenerate axis with nonzero distance")
    `PTCD_ASSERT_SAME(a_stall_blocks_in, out_ch.valid && !out_ch.ready,
        !in_ch.ready, "input accepted while output stalled")
    `PTCD_ASSERT_NEXT(a_accept_enters, in_ch.valid && in_ch.ready,
        s1_v_reg, "accepted item missing from first stage")

endmodule

[sim/ptcd_tb_ifs.sv]
// ---------------------------------------------------------------------------
// Point-to-cylinder distance testbench channels
// Notes on the channel interfaces that the bench instantiates from the RTL.
// ---------------------------------------------------------------------------
// The bench uses ptcd_point_if, ptcd_dist_if and ptcd_cfg_if from the RTL
// source tree directly; this file holds a small helper package only.
package ptcd_tb_pkg;
    localparam int CW = 32;
    localparam int LATENCY = 5 * CW + 18;
endpackage

[sim/tb.sv]
// ---------------------------------------------------------------------------
// Point-to-cylinder distance unit testbench
// Streams query points through the unit under several cylinder settings,
// predicts each distance with wide exact integer math, and checks every
// result in order under random idling on both sides.
// ---------------------------------------------------------------------------
module tb;
    import ptcd_pkg::*;
    import ptcd_tb_pkg::*;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
    } point_t;

    typedef struct packed {
        logic [CW-1:0] distance;
        logic          degen;
    } dist_t;

    logic clk;
    logic rst_n;

    ptcd_cfg_if   #(.COORD_WIDTH(CW)) cfg_ch ();
    ptcd_point_if #(.COORD_WIDTH(CW)) in_ch ();
    ptcd_dist_if  #(.COORD_WIDTH(CW)) out_ch ();

    point_to_cylinder_distance_unit #(.COORD_WIDTH(CW)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_ch (cfg_ch.sink),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // cylinder copy held by the predictor
    logic signed [CW-1:0] cyl_start [3];
    logic signed [CW-1:0] cyl_axis [3];
    logic [CW-2:0]        cyl_radius;

    point_t pending_points [$];
    dist_t  expected_dists [$];
    int     errors;
    int     points_sent;
    int     dists_checked;
    int     idle_cycles;
    int     in_wait;
    int     out_wait;
    int     in_draw;
    int     out_draw;
    point_t in_item;

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // floor integer square root
    function automatic logic [191:0] isqrt(input logic [191:0] v);
        logic [191:0] r;
        logic [191:0] c;
        r = '0;
        for (int b = 95; b >= 0; b--)
        begin
            c = r | (192'd1 << b);
            if (c * c <= v)
                r = c;
        end
        return r;
    endfunction

    // expected distance for one point
    function automatic dist_t cylinder_distance(input point_t p);
        logic signed [CW-1:0] pc [3];
        logic [191:0] pos, neg, dd, aa, dotmag, len, proj, p2, perp, excess;
        logic [191:0] hull, res, rw, dm, am, lim;
        logic signed [CW:0] d;
        logic signed [CW:0] a;
        bit dneg, aneg, in_hull;
        dist_t r;
        pc[0] = p.x;
        pc[1] = p.y;
        pc[2] = p.z;
        pos = '0;
        neg = '0;
        dd = '0;
        aa = '0;
        for (int k = 0; k < 3; k++)
        begin
            d = $signed(pc[k]) - $signed(cyl_start[k]);
            a = cyl_axis[k];
            dneg = d < 0;
            aneg = a < 0;
            dm = dneg ? 192'(-d) : 192'(d);
            am = aneg ? 192'(-a) : 192'(a);
            if (dneg != aneg)
                neg += dm * am;
            else
                pos += dm * am;
            dd += dm * dm;
            aa += am * am;
        end
        r.degen = 1'b0;
        if (aa == 0)
        begin
            r.distance = '0;
            r.degen = 1'b1;
            return r;
        end
        dotmag = (pos >= neg) ? pos - neg : neg - pos;
        len = isqrt(aa);
        proj = dotmag / len;
        p2 = proj * proj;
        perp = isqrt(dd >= p2 ? dd - p2 : 192'd0);
        if (pos <= neg)
            excess = proj;
        else if (dotmag >= aa)
            excess = proj - len;
        else
            excess = '0;
        rw = 192'(cyl_radius);
        in_hull = perp < rw;
        hull = in_hull ? rw - perp : perp - rw;
        res = isqrt(hull * hull + excess * excess);
        lim = in_hull ? (192'd1 << (CW - 1)) : (192'd1 << (CW - 1)) - 1;
        if (res > lim)
            res = lim;
        r.distance = in_hull ? CW'(-res) : CW'(res);
        return r;
    endfunction

    // one register write, block idle
    task automatic write_reg(input cfg_idx_t idx, input logic [CW-1:0] v);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_START_X: cyl_start[0] = v;
            CFG_START_Y: cyl_start[1] = v;
            CFG_START_Z: cyl_start[2] = v;
            CFG_AXIS_X:  cyl_axis[0] = v;
            CFG_AXIS_Y:  cyl_axis[1] = v;
            CFG_AXIS_Z:  cyl_axis[2] = v;
            CFG_RADIUS:  cyl_radius = v[CW-2:0];
            default: ;
        endcase
    endtask

    task automatic set_cylinder(input logic [CW-1:0] sx, sy, sz, ax, ay, az, rad);
        write_reg(CFG_START_X, sx);
        write_reg(CFG_START_Y, sy);
        write_reg(CFG_START_Z, sz);
        write_reg(CFG_AXIS_X, ax);
        write_reg(CFG_AXIS_Y, ay);
        write_reg(CFG_AXIS_Z, az);
        write_reg(CFG_RADIUS, rad);
    endtask

    // wait until the pipeline is drained
    task automatic drain();
        while (pending_points.size() != 0 || expected_dists.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    function automatic logic [CW-1:0] rand_coord(input int mode);
        case (mode)
            0: return $urandom;
            1: return CW'($signed($urandom_range(0, 20'hfffff)) - 32'sh80000);
            default: return CW'($signed($urandom_range(0, 24'hffffff)) - 32'sh800000);
        endcase
    endfunction

    task automatic push_point(input logic [CW-1:0] x, y, z);
        point_t p;
        p.x = x;
        p.y = y;
        p.z = z;
        pending_points = {pending_points, p};
    endtask

    task automatic random_phase(input int n, input int mode);
        for (int i = 0; i < n; i++)
            push_point(rand_coord(mode), rand_coord(mode), rand_coord(mode));
        drain();
    endtask

    // driver: random gaps, next item right away when the drawn wait is zero
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_wait <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                in_item = pending_points.pop_front();
                expected_dists = {expected_dists, cylinder_distance(in_item)};
                points_sent <= points_sent + 1;
                in_draw = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 15));
                if (in_draw == 0 && pending_points.size() != 0)
                begin
                    in_ch.valid <= 1'b1;
                    in_ch.point_x <= pending_points[0].x;
                    in_ch.point_y <= pending_points[0].y;
                    in_ch.point_z <= pending_points[0].z;
                    in_wait <= 0;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                    in_wait <= (in_draw == 0) ? 0 : in_draw - 1;
                end
            end
            else if (!in_ch.valid && pending_points.size() != 0)
            begin
                if (in_wait > 0)
                    in_wait <= in_wait - 1;
                else
                begin
                    in_ch.valid <= 1'b1;
                    in_ch.point_x <= pending_points[0].x;
                    in_ch.point_y <= pending_points[0].y;
                    in_ch.point_z <= pending_points[0].z;
                end
            end
        end
    end

    // monitor and result stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            out_wait <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_dists.size() == 0)
                begin
                    $error("unexpected result");
                    errors++;
                end
                else
                begin
                    dist_t e;
                    e = expected_dists.pop_front();
                    if (out_ch.signed_distance !== e.distance)
                    begin
                        $error("signed_distance exp %0d got %0d",
                               $signed(e.distance), out_ch.signed_distance);
                        errors++;
                    end
                    if (out_ch.axis_degenerate !== e.degen)
                    begin
                        $error("axis_degenerate exp %0d got %0d",
                               e.degen, out_ch.axis_degenerate);
                        errors++;
                    end
                end
                dists_checked++;
                out_draw = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 15));
                if (out_draw == 0)
                begin
                    out_ch.ready <= 1'b1;
                    out_wait <= 0;
                end
                else
                begin
                    out_ch.ready <= 1'b0;
                    out_wait <= out_draw - 1;
                end
            end
            else if (out_wait > 0)
            begin
                out_wait <= out_wait - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            cfg_ch.valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 4 * LATENCY + 2000)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        errors = 0;
        points_sent = 0;
        dists_checked = 0;
        idle_cycles = 0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        in_ch.point_x = '0;
        in_ch.point_y = '0;
        in_ch.point_z = '0;
        for (int k = 0; k < 3; k++)
        begin
            cyl_start[k] = '0;
            cyl_axis[k] = '0;
        end
        cyl_radius = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset state: zero axis is degenerate
        push_point(32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff);
        drain();

        // unit cylinder on z, directed points
        set_cylinder(0, 0, 0, 0, 0, 32'h0001_0000, 32'h0000_8000);
        push_point(0, 0, 32'h0000_8000);          // inside, on axis
        push_point(32'h0000_8000, 0, 32'h0000_8000); // on the hull
        push_point(32'h0002_0000, 0, 32'h0000_8000); // outside radially
        push_point(0, 0, 32'hfffe_0000);          // below start
        push_point(0, 0, 32'h0003_0000);          // beyond end
        push_point(0, 0, 0);                      // exactly at start
        push_point(0, 0, 32'h0001_0000);          // exactly at end
        push_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        push_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_point(32'hffff_ffff, 32'h0000_0001, 32'h8000_0000);
        drain();

        // extreme settings: max radius, extreme start, min axis
        set_cylinder(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
        push_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        push_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        push_point(0, 0, 0);
        random_phase(40, 0);

        // moderate cylinder, mostly in-range points
        set_cylinder(32'h0001_0000, 32'hffff_0000, 32'h0002_0000,
                     32'h0004_0000, 32'h0003_0000, 32'hfffe_0000, 32'h0002_0000);
        random_phase(150, 1);

        // random cylinders
        for (int ph = 0; ph < 3; ph++)
        begin
            set_cylinder(rand_coord(2), rand_coord(2), rand_coord(2),
                         rand_coord(ph == 2 ? 0 : 2), rand_coord(2), rand_coord(2),
                         {1'b0, 31'($urandom_range(0, 24'hffffff))});
            random_phase(100, ph == 2 ? 0 : 2);
        end

        // zero radius, axis on x, then back to zero axis
        set_cylinder(0, 0, 0, 32'h0000_0001, 0, 0, 0);
        random_phase(40, 1);
        set_cylinder(rand_coord(0), rand_coord(0), rand_coord(0), 0, 0, 0,
                     {1'b0, 31'($urandom)});
        random_phase(20, 0);

        $display("run covered %0d points and %0d results over several cylinders,",
                 points_sent, dists_checked);
        $display("including zero axis, extreme coordinates and saturation");
        if (errors == 0 && expected_dists.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

[sim.f]
+incdir+src
src/ptcd_pkg.sv
src/ptcd_ifs.sv
src/ptcd_sqrt_pipe.sv
src/ptcd_div_pipe.sv
src/point_to_cylinder_distance_unit.sv
sim/ptcd_tb_ifs.sv
sim/tb.sv
